[hw/rtl/phd_pkg.sv]
package phd_pkg;

    // Default sizes of the decoder.
    localparam int LEN_LIMIT_DEF = 24;
    localparam int MAX_NODES_DEF = 514;

    // Widths fixed by the code construction.
    localparam int LEVEL_W = 5;
    localparam int RC_W    = 25;
    localparam int SYM_W   = 9;

    localparam logic [RC_W-1:0]    RC_INIT   = 25'h100_0000;
    localparam logic [SYM_W-1:0]   END_SYM   = 9'd256;
    localparam logic [7:0]         COUNT_MAX = 8'd253;
    localparam logic [LEVEL_W-1:0] TOP_BIT   = 5'd23;

    // Result status codes.
    localparam logic [1:0] ST_SYMBOL = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

endpackage

[hw/rtl/phd_ram.sv]
module phd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pack_huffman_decoder.sv]
// Channel   Direction  Handshake              Fields
// input     in         start high, busy low   i_in_byte, i_in_last
// result    out        o_valid, one cycle     o_out_symbol, o_status, o_out_last
// config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// A header byte goes through S_END1 and S_END2; the last count first steps through the
// lengths in S_OPEN and S_BLD. A symbol byte walks from the root, level by level
// through the node memory, then steps on and may place the end code. A body byte
// reads the root, then takes one bit a cycle except where a leaf is reached (S_LEAF,
// then a new read of the root, or S_SUCC to report success).
// Synchronous active-low reset; after reset and after each final byte the S_INIT state
// writes the root node, with busy high. Results cannot be held off.
module pack_huffman_decoder #(
    parameter int LEN_LIMIT = phd_pkg::LEN_LIMIT_DEF,
    parameter int MAX_NODES = phd_pkg::MAX_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    output logic [7:0]  o_out_symbol,
    output logic [1:0]  o_status,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int NUW    = $clog2(MAX_NODES + 1);
    localparam int LIW    = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;
    localparam int NODE_W = 2 * NW + phd_pkg::SYM_W + 1;
    localparam int LW     = phd_pkg::LEVEL_W;
    localparam int RW     = phd_pkg::RC_W;
    localparam int SW     = phd_pkg::SYM_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_OPEN, S_BLD, S_INS_RD, S_INS_CHK, S_INS_NEW,
        S_DEC_RD, S_DEC_BIT, S_LEAF, S_SUCC, S_END1, S_END2
    } t_state;

    typedef enum logic [2:0] {
        PH_MAXLEN, PH_COUNTS, PH_SYMS, PH_DECODE, PH_DONE, PH_ERROR
    } t_phase;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [7:0]      r_byte, n_byte;
    logic            r_last, n_last;
    logic [LW-1:0]   r_top, n_top;
    logic [LW-1:0]   r_level, n_level;
    logic [7:0]      r_symidx, n_symidx;
    logic [RW-1:0]   r_rc, n_rc;
    logic [NUW-1:0]  r_nodes, n_nodes;
    logic [NW-1:0]   r_walk, n_walk;
    logic [NW-1:0]   r_node, n_node;
    logic [LW-1:0]   r_depth, n_depth;
    logic [SW-1:0]   r_ins_sym, n_ins_sym;
    logic [3:0]      r_bits, n_bits;
    logic [SW-1:0]   r_leaf_sym, n_leaf_sym;
    logic [31:0]     r_emitted, n_emitted;
    logic            r_pend_v, n_pend_v;
    logic [7:0]      r_pend_sym, n_pend_sym;
    logic [1:0]      r_pend_st, n_pend_st;
    logic            r_o_valid, n_o_valid;
    logic [7:0]      r_o_sym, n_o_sym;
    logic [1:0]      r_o_st, n_o_st;
    logic            r_o_last, n_o_last;
    logic [31:0]     r_sym_count;
    logic            r_req_end;
    logic [7:0]      r_counts [LEN_LIMIT];

    logic            cnt_we;
    logic [7:0]      cnt_wdata;
    logic            ram_we;
    logic [NW-1:0]   ram_waddr;
    logic [NODE_W-1:0] ram_wdata;
    logic [NW-1:0]   ram_raddr;
    logic [NODE_W-1:0] ram_rdata;

    logic            push_v;
    logic [7:0]      push_sym;
    logic [1:0]      push_st;
    logic            flush;

    logic [7:0]      cnt;
    logic [LW-1:0]   sh;
    logic [RW-1:0]   step;
    logic [30:0]     prod;
    logic [SW-1:0]   d_sym;
    logic            d_leaf;
    logic [NW-1:0]   d_kid0, d_kid1;
    logic            ins_bit, dec_bit;
    logic [NW-1:0]   ins_next, dec_next;
    logic [2:0]      bit_pos;

    // Node memory: child indexes, leaf flag and symbol.
    phd_ram #(
        .WIDTH(NODE_W),
        .DEPTH(MAX_NODES)
    ) u_tree (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign d_sym  = ram_rdata[SW-1:0];
    assign d_leaf = ram_rdata[SW];
    assign d_kid0 = ram_rdata[SW+1 +: NW];
    assign d_kid1 = ram_rdata[SW+1+NW +: NW];

    // Code space arithmetic of the current level.
    assign cnt  = r_counts[r_level[LIW-1:0]];
    assign sh   = phd_pkg::TOP_BIT - r_level;
    assign step = RW'(1) << sh;
    assign prod = 31'(cnt) << sh;

    // Branch bits for insertion and for the tree walk.
    assign ins_bit  = r_rc[phd_pkg::TOP_BIT - r_depth];
    assign ins_next = ins_bit ? d_kid1 : d_kid0;
    assign bit_pos  = 3'(r_bits - 4'd1);
    assign dec_bit  = r_byte[bit_pos];
    assign dec_next = dec_bit ? d_kid1 : d_kid0;

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_out_symbol = r_o_sym;
    assign o_status     = r_o_st;
    assign o_out_last   = r_o_last;

    // Sequencer: header parse, tree build and bit-serial decode.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_byte     = r_byte;
        n_last     = r_last;
        n_top      = r_top;
        n_level    = r_level;
        n_symidx   = r_symidx;
        n_rc       = r_rc;
        n_nodes    = r_nodes;
        n_walk     = r_walk;
        n_node     = r_node;
        n_depth    = r_depth;
        n_ins_sym  = r_ins_sym;
        n_bits     = r_bits;
        n_leaf_sym = r_leaf_sym;
        n_emitted  = r_emitted;
        cnt_we     = 1'b0;
        cnt_wdata  = r_byte;
        ram_we     = 1'b0;
        ram_waddr  = r_node;
        ram_wdata  = '0;
        ram_raddr  = r_node;
        push_v     = 1'b0;
        push_sym   = 8'd0;
        push_st    = phd_pkg::ST_SYMBOL;
        flush      = 1'b0;

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                n_nodes   = NUW'(1);
                n_rc      = phd_pkg::RC_INIT;
                n_phase   = PH_MAXLEN;
                n_level   = '0;
                n_symidx  = '0;
                n_walk    = '0;
                n_emitted = '0;
                n_top     = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_byte  = i_in_byte;
                    n_last  = i_in_last;
                    n_state = S_END1;
                    case (r_phase)
                        PH_MAXLEN: begin
                            if (i_in_byte == 8'd0 || i_in_byte > 8'(LEN_LIMIT)) begin
                                push_v  = 1'b1;
                                push_st = phd_pkg::ST_ERROR;
                                n_phase = PH_ERROR;
                            end else begin
                                n_top   = i_in_byte[LW-1:0];
                                n_level = '0;
                                n_phase = PH_COUNTS;
                            end
                        end
                        PH_COUNTS: begin
                            cnt_we    = 1'b1;
                            cnt_wdata = i_in_byte;
                            if (r_level + LW'(1) >= r_top) begin
                                if (i_in_byte > phd_pkg::COUNT_MAX) begin
                                    push_v  = 1'b1;
                                    push_st = phd_pkg::ST_ERROR;
                                    n_phase = PH_ERROR;
                                end else begin
                                    cnt_wdata = i_in_byte + 8'd2;
                                    n_level   = '0;
                                    n_symidx  = '0;
                                    n_state   = S_OPEN;
                                end
                            end else begin
                                n_level = r_level + LW'(1);
                            end
                        end
                        PH_SYMS: begin
                            n_ins_sym = {1'b0, i_in_byte};
                            n_node    = '0;
                            n_depth   = '0;
                            n_state   = S_INS_RD;
                        end
                        PH_DECODE: begin
                            n_bits  = 4'd8;
                            n_state = S_DEC_RD;
                        end
                        default: begin
                            n_state = S_END1;
                        end
                    endcase
                end
            end
            S_OPEN: begin
                if (r_level >= r_top) begin
                    n_state = S_BLD;
                end else if (prod > 31'(r_rc)) begin
                    push_v  = 1'b1;
                    push_st = phd_pkg::ST_ERROR;
                    n_phase = PH_ERROR;
                    n_state = S_END1;
                end else begin
                    n_rc    = r_rc - prod[RW-1:0];
                    n_state = S_BLD;
                end
            end
            S_BLD: begin
                if (r_level >= r_top) begin
                    // Tree complete: start decoding, or report done if no symbols and no end code are due.
                    n_phase = PH_DECODE;
                    n_walk  = '0;
                    n_state = S_END1;
                    if (r_emitted >= r_sym_count && !r_req_end) begin
                        push_v  = 1'b1;
                        push_st = phd_pkg::ST_DONE;
                        n_phase = PH_DONE;
                    end
                end else if (r_symidx < cnt) begin
                    if (r_level == r_top - LW'(1) && r_symidx == cnt - 8'd1) begin
                        n_ins_sym = phd_pkg::END_SYM;
                        n_node    = '0;
                        n_depth   = '0;
                        n_state   = S_INS_RD;
                    end else begin
                        n_phase = PH_SYMS;
                        n_state = S_END1;
                    end
                end else begin
                    n_rc     = r_rc - prod[RW-1:0];
                    n_level  = r_level + LW'(1);
                    n_symidx = '0;
                    n_state  = S_OPEN;
                end
            end
            S_INS_RD: begin
                ram_raddr = r_node;
                n_state   = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (d_leaf) begin
                    push_v  = 1'b1;
                    push_st = phd_pkg::ST_ERROR;
                    n_phase = PH_ERROR;
                    n_state = S_END1;
                end else if (r_depth == r_level + LW'(1)) begin
                    if (d_kid0 != '0 || d_kid1 != '0) begin
                        push_v  = 1'b1;
                        push_st = phd_pkg::ST_ERROR;
                        n_phase = PH_ERROR;
                        n_state = S_END1;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = {d_kid1, d_kid0, 1'b1, r_ins_sym};
                        n_rc      = r_rc + step;
                        n_symidx  = r_symidx + 8'd1;
                        n_state   = S_BLD;
                    end
                end else if (ins_next != '0) begin
                    n_node  = ins_next;
                    n_depth = r_depth + LW'(1);
                    n_state = S_INS_RD;
                end else if (r_nodes >= NUW'(MAX_NODES)) begin
                    push_v  = 1'b1;
                    push_st = phd_pkg::ST_ERROR;
                    n_phase = PH_ERROR;
                    n_state = S_END1;
                end else begin
                    // Link a fresh child, then clear it.
                    ram_we = 1'b1;
                    if (ins_bit) begin
                        ram_wdata = {r_nodes[NW-1:0], d_kid0, 1'b0, d_sym};
                    end else begin
                        ram_wdata = {d_kid1, r_nodes[NW-1:0], 1'b0, d_sym};
                    end
                    n_node  = r_nodes[NW-1:0];
                    n_nodes = r_nodes + NUW'(1);
                    n_depth = r_depth + LW'(1);
                    n_state = S_INS_NEW;
                end
            end
            S_INS_NEW: begin
                ram_we  = 1'b1;
                n_state = S_INS_RD;
            end
            S_DEC_RD: begin
                ram_raddr = r_walk;
                n_state   = S_DEC_BIT;
            end
            S_DEC_BIT: begin
                if (d_leaf) begin
                    n_leaf_sym = d_sym;
                    n_walk     = '0;
                    n_state    = S_LEAF;
                end else if (r_bits == 4'd0) begin
                    n_state = S_END1;
                end else if (dec_next == '0) begin
                    push_v  = 1'b1;
                    push_st = phd_pkg::ST_ERROR;
                    n_phase = PH_ERROR;
                    n_state = S_END1;
                end else begin
                    n_walk    = dec_next;
                    n_bits    = r_bits - 4'd1;
                    ram_raddr = dec_next;
                    n_state   = S_DEC_BIT;
                end
            end
            S_LEAF: begin
                n_state = (r_bits != 4'd0) ? S_DEC_RD : S_END1;
                if (r_emitted < r_sym_count) begin
                    if (r_leaf_sym == phd_pkg::END_SYM) begin
                        push_v  = 1'b1;
                        push_st = phd_pkg::ST_ERROR;
                        n_phase = PH_ERROR;
                        n_state = S_END1;
                    end else begin
                        push_v    = 1'b1;
                        push_sym  = r_leaf_sym[7:0];
                        n_emitted = r_emitted + 32'd1;
                        if (n_emitted >= r_sym_count && !r_req_end) begin
                            n_state = S_SUCC;
                        end
                    end
                end else if (r_req_end && r_leaf_sym != phd_pkg::END_SYM) begin
                    push_v  = 1'b1;
                    push_st = phd_pkg::ST_ERROR;
                    n_phase = PH_ERROR;
                    n_state = S_END1;
                end else begin
                    push_v  = 1'b1;
                    push_st = phd_pkg::ST_DONE;
                    n_phase = PH_DONE;
                    n_state = S_END1;
                end
            end
            S_SUCC: begin
                push_v  = 1'b1;
                push_st = phd_pkg::ST_DONE;
                n_phase = PH_DONE;
                n_state = S_END1;
            end
            S_END1: begin
                // A final byte before the job is over is an error.
                if (r_last && r_phase != PH_DONE && r_phase != PH_ERROR) begin
                    push_v  = 1'b1;
                    push_st = phd_pkg::ST_ERROR;
                    n_phase = PH_ERROR;
                end
                n_state = S_END2;
            end
            S_END2: begin
                flush   = 1'b1;
                n_state = r_last ? S_INIT : S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // One-deep result buffer, so that the last result of a byte can be marked.
    always_comb begin
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_pend_st  = r_pend_st;
        n_o_valid  = 1'b0;
        n_o_sym    = r_o_sym;
        n_o_st     = r_o_st;
        n_o_last   = r_o_last;
        if (push_v) begin
            if (r_pend_v) begin
                n_o_valid = 1'b1;
                n_o_sym   = r_pend_sym;
                n_o_st    = r_pend_st;
                n_o_last  = 1'b0;
            end
            n_pend_v   = 1'b1;
            n_pend_sym = push_sym;
            n_pend_st  = push_st;
        end else if (flush && r_pend_v) begin
            n_o_valid = 1'b1;
            n_o_sym   = r_pend_sym;
            n_o_st    = r_pend_st;
            n_o_last  = 1'b1;
            n_pend_v  = 1'b0;
        end
    end

    // State, registers and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_phase     <= PH_MAXLEN;
            r_last      <= 1'b0;
            r_top       <= '0;
            r_level     <= '0;
            r_symidx    <= '0;
            r_rc        <= phd_pkg::RC_INIT;
            r_nodes     <= NUW'(1);
            r_walk      <= '0;
            r_node      <= '0;
            r_depth     <= '0;
            r_bits      <= '0;
            r_emitted   <= '0;
            r_pend_v    <= 1'b0;
            r_o_valid   <= 1'b0;
            r_sym_count <= '0;
            r_req_end   <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_last    <= n_last;
            r_top     <= n_top;
            r_level   <= n_level;
            r_symidx  <= n_symidx;
            r_rc      <= n_rc;
            r_nodes   <= n_nodes;
            r_walk    <= n_walk;
            r_node    <= n_node;
            r_depth   <= n_depth;
            r_bits    <= n_bits;
            r_emitted <= n_emitted;
            r_pend_v  <= n_pend_v;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                if (i_cfg_index) begin
                    r_req_end <= i_cfg_data[0];
                end else begin
                    r_sym_count <= i_cfg_data;
                end
            end
        end
        r_byte     <= n_byte;
        r_ins_sym  <= n_ins_sym;
        r_leaf_sym <= n_leaf_sym;
        r_pend_sym <= n_pend_sym;
        r_pend_st  <= n_pend_st;
        r_o_sym    <= n_o_sym;
        r_o_st     <= n_o_st;
        r_o_last   <= n_o_last;
        if (cnt_we) begin
            r_counts[r_level[LIW-1:0]] <= cnt_wdata;
        end
    end

endmodule
